### rtl/core/ard_pkg.sv
package ard_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned RANGE_W  = 17;
    localparam int unsigned PARTS_W  = 15;
    localparam int unsigned VALUE_W  = 14;
    localparam int unsigned USED_W   = 5;
    localparam int unsigned PROD_W   = 31;
    localparam int unsigned CNT_W    = 5;

    localparam logic [WORD_W-1:0] HALF_POINT    = 16'h8000;
    localparam logic [WORD_W-1:0] QUARTER_POINT = 16'h4000;
    localparam logic [WORD_W-1:0] THREE_QUARTER = 16'hC000;
    localparam logic [WORD_W-1:0] FULL_MASK     = 16'hFFFF;

    localparam logic [PARTS_W-1:0] MAX_MODULUS = 15'd16384;
    localparam logic [3:0]         MAX_BITS    = 4'd14;

    localparam logic [CNT_W-1:0] NARROW_STEPS = 5'd14;
    localparam logic [CNT_W-1:0] WIDE_STEPS   = 5'd17;
    localparam logic [USED_W-1:0] WINDOW_BITS = 5'd16;

    localparam logic [1:0] ACT_INIT  = 2'd0;
    localparam logic [1:0] ACT_EQUAL = 2'd1;
    localparam logic [1:0] ACT_RAW   = 2'd2;
    localparam logic [1:0] ACT_NOP   = 2'd3;

    typedef struct packed {
        logic start;
        logic wide;
    } div_req_t;

endpackage

### rtl/core/arith_range_decoder_16bit.sv
// 16-bit arithmetic range decoder with a shared restoring divider.
// input channel s_*: one word per operation; s_tuser carries the action
// (init from window, decode equal-probability number, decode raw bits,
// no-op) and s_tdata the modulus, bit count and 16-bit look-ahead window.
// output channel m_*: one result word per input word, giving the decoded
// value and the number of window bits used, with m_tuser flagging a code
// that had to be clamped into the interval.
// init and no-op words go from idle straight to the finish state. a
// decode word runs one multiply, a 14-step divide for the part index,
// a second multiply, two 17-step divides for the new bounds, then one
// renormalisation shift per cycle (up to 16). the divider works one
// quotient bit per cycle.
// s_tready is high only while no word is in progress; one word at a time.
// a finished result sits in an output register, so a new word is taken
// while that result waits; if m_tready stays low the next result waits
// in the sequencer and s_tready stays low.
// reset (rst_n low, asynchronous) sets low to 0, high to 0xFFFF, code to 0
// and empties the output register.
module arith_range_decoder_16bit
    import ard_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // modulus[14:0], bit_count[18:15], stream_window[34:19]
    input  logic [1:0]  s_tuser,   // action[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // decoded_value[13:0], bits_used[18:14]
    output logic        m_tuser    // corrupt[0]
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_MULA   = 4'd2;
    localparam logic [3:0] S_DIVA   = 4'd3;
    localparam logic [3:0] S_WAITA  = 4'd4;
    localparam logic [3:0] S_MULB   = 4'd5;
    localparam logic [3:0] S_DIVB   = 4'd6;
    localparam logic [3:0] S_WAITB  = 4'd7;
    localparam logic [3:0] S_DIVC   = 4'd8;
    localparam logic [3:0] S_WAITC  = 4'd9;
    localparam logic [3:0] S_RENORM = 4'd10;
    localparam logic [3:0] S_FIN    = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [WORD_W-1:0]   low_reg, low_next;
    logic [WORD_W-1:0]   high_reg, high_next;
    logic [WORD_W-1:0]   code_reg, code_next;
    logic [RANGE_W-1:0]  range_reg, range_next;
    logic [RANGE_W-1:0]  num_reg, num_next;
    logic [PARTS_W-1:0]  parts_reg, parts_next;
    logic [WORD_W-1:0]   win_reg, win_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [USED_W-1:0]   used_reg, used_next;
    logic                bad_reg, bad_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [RANGE_W-1:0]  qh_reg, qh_next;
    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  out_val_reg, out_val_next;
    logic [USED_W-1:0]   out_used_reg, out_used_next;
    logic                out_bad_reg, out_bad_next;

    logic [1:0]          in_action;
    logic [PARTS_W-1:0]  in_modulus;
    logic [3:0]          in_bits;
    logic [WORD_W-1:0]   in_window;
    logic [3:0]          sat_bits;
    logic                accept;

    logic [WORD_W-1:0]   hi_guard;
    logic [WORD_W-1:0]   code_clamp;
    logic [RANGE_W-1:0]  mul_a;
    logic [PARTS_W-1:0]  mul_b;
    logic [PROD_W-1:0]   mul_p;

    div_req_t            dreq;
    logic [PROD_W-1:0]   d_dividend;
    logic [RANGE_W-1:0]  d_divisor;
    logic                d_done;
    logic [RANGE_W-1:0]  d_quot;

    logic [WORD_W-1:0]   r_low, r_high, r_code;
    logic                r_stop;

    assign in_modulus = s_tdata[14:0];
    assign in_bits    = s_tdata[18:15];
    assign in_window  = s_tdata[34:19];
    assign in_action  = s_tuser;
    assign sat_bits   = (in_bits > MAX_BITS) ? MAX_BITS : in_bits;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign hi_guard   = (high_reg < low_reg) ? low_reg : high_reg;
    assign code_clamp = (code_reg < low_reg) ? low_reg :
                        ((code_reg > hi_guard) ? hi_guard : code_reg);

    // one shared multiplier for the scaled code and the part base
    assign mul_a = (state_reg == S_MULA) ? num_reg : range_reg;
    assign mul_b = (state_reg == S_MULA) ? parts_reg : {1'b0, val_reg};
    assign mul_p = PROD_W'(mul_a * mul_b);

    always_comb
    begin
        dreq.start = (state_reg == S_DIVA) || (state_reg == S_DIVB) ||
                     (state_reg == S_DIVC);
        dreq.wide  = (state_reg != S_DIVA);
        case (state_reg)
            S_DIVA:  d_dividend = prod_reg - 31'd1;
            S_DIVB:  d_dividend = prod_reg + {14'd0, range_reg};
            default: d_dividend = prod_reg;
        endcase
        d_divisor = (state_reg == S_DIVA) ? range_reg : {2'b00, parts_reg};
    end

    ard_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (dreq),
        .dividend (d_dividend),
        .divisor  (d_divisor),
        .done     (d_done),
        .quotient (d_quot)
    );

    // one renormalisation shift
    always_comb
    begin
        r_low  = low_reg;
        r_high = high_reg;
        r_code = code_reg;
        r_stop = 1'b0;
        if (high_reg >= HALF_POINT)
        begin
            if (low_reg < HALF_POINT)
            begin
                if (low_reg >= QUARTER_POINT && high_reg < THREE_QUARTER)
                begin
                    r_low  = low_reg - QUARTER_POINT;
                    r_high = high_reg - QUARTER_POINT;
                    r_code = code_reg - QUARTER_POINT;
                end
                else
                    r_stop = 1'b1;
            end
            else
            begin
                r_low  = low_reg - HALF_POINT;
                r_high = high_reg - HALF_POINT;
                r_code = code_reg - HALF_POINT;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        code_next      = code_reg;
        range_next     = range_reg;
        num_next       = num_reg;
        parts_next     = parts_reg;
        win_next       = win_reg;
        val_next       = val_reg;
        used_next      = used_reg;
        bad_next       = bad_reg;
        prod_next      = prod_reg;
        qh_next        = qh_reg;
        out_valid_next = out_valid_reg;
        out_val_next   = out_val_reg;
        out_used_next  = out_used_reg;
        out_bad_next   = out_bad_reg;

        if (m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    win_next  = in_window;
                    val_next  = '0;
                    used_next = '0;
                    bad_next  = 1'b0;
                    if (in_action == ACT_RAW)
                        parts_next = PARTS_W'(16'd1 << sat_bits);
                    else if (in_modulus == '0)
                        parts_next = 15'd1;
                    else if (in_modulus > MAX_MODULUS)
                        parts_next = MAX_MODULUS;
                    else
                        parts_next = in_modulus;
                    case (in_action)
                        ACT_INIT:
                        begin
                            low_next   = '0;
                            high_next  = FULL_MASK;
                            code_next  = in_window;
                            used_next  = WINDOW_BITS;
                            state_next = S_FIN;
                        end
                        ACT_EQUAL, ACT_RAW:
                            state_next = S_PREP;
                        default:
                            state_next = S_FIN;
                    endcase
                end
            end
            S_PREP:
            begin
                bad_next   = (code_reg < low_reg) || (code_reg > hi_guard);
                code_next  = code_clamp;
                range_next = RANGE_W'({1'b0, hi_guard} - {1'b0, low_reg} + 17'd1);
                num_next   = RANGE_W'({1'b0, code_clamp} - {1'b0, low_reg} + 17'd1);
                state_next = S_MULA;
            end
            S_MULA:
            begin
                prod_next  = mul_p;
                state_next = S_DIVA;
            end
            S_DIVA:
                state_next = S_WAITA;
            S_WAITA:
            begin
                if (d_done)
                begin
                    val_next   = d_quot[VALUE_W-1:0];
                    state_next = S_MULB;
                end
            end
            S_MULB:
            begin
                prod_next  = mul_p;
                state_next = S_DIVB;
            end
            S_DIVB:
                state_next = S_WAITB;
            S_WAITB:
            begin
                if (d_done)
                begin
                    qh_next    = d_quot;
                    state_next = S_DIVC;
                end
            end
            S_DIVC:
                state_next = S_WAITC;
            S_WAITC:
            begin
                if (d_done)
                begin
                    high_next  = WORD_W'(qh_reg + {1'b0, low_reg} - 17'd1);
                    low_next   = WORD_W'(d_quot + {1'b0, low_reg});
                    used_next  = '0;
                    state_next = S_RENORM;
                end
            end
            S_RENORM:
            begin
                if (used_reg == WINDOW_BITS || r_stop)
                    state_next = S_FIN;
                else
                begin
                    code_next = {r_code[WORD_W-2:0], win_reg[WORD_W-1]};
                    low_next  = {r_low[WORD_W-2:0], 1'b0};
                    high_next = {r_high[WORD_W-2:0], 1'b1};
                    win_next  = {win_reg[WORD_W-2:0], 1'b0};
                    used_next = used_reg + 5'd1;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = val_reg;
                    out_used_next  = used_reg;
                    out_bad_next   = bad_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            low_reg       <= '0;
            high_reg      <= FULL_MASK;
            code_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            code_reg      <= code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        range_reg    <= range_next;
        num_reg      <= num_next;
        parts_reg    <= parts_next;
        win_reg      <= win_next;
        val_reg      <= val_next;
        used_reg     <= used_next;
        bad_reg      <= bad_next;
        prod_reg     <= prod_next;
        qh_reg       <= qh_next;
        out_val_reg  <= out_val_next;
        out_used_reg <= out_used_next;
        out_bad_reg  <= out_bad_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_used_reg, out_val_reg};
    assign m_tuser  = out_bad_reg;

endmodule

### rtl/core/ard_div.sv
module ard_div
    import ard_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    input  logic [PROD_W-1:0]    dividend,
    input  logic [RANGE_W-1:0]   divisor,
    output logic                 done,
    output logic [RANGE_W-1:0]   quotient
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RANGE_W-1:0]  rem_reg, rem_next;
    logic [RANGE_W-1:0]  sh_reg, sh_next;
    logic [RANGE_W-1:0]  quo_reg, quo_next;
    logic [RANGE_W-1:0]  div_reg, div_next;
    logic [RANGE_W:0]    trial;
    logic                ge;

    assign trial = {rem_reg, sh_reg[RANGE_W-1]};
    assign ge    = (trial >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            div_next  = divisor;
            quo_next  = '0;
            if (req.wide)
            begin
                cnt_next = WIDE_STEPS;
                rem_next = {3'b000, dividend[PROD_W-1:17]};
                sh_next  = dividend[16:0];
            end
            else
            begin
                cnt_next = NARROW_STEPS;
                rem_next = dividend[PROD_W-1:14];
                sh_next  = {dividend[13:0], 3'b000};
            end
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_next = RANGE_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[RANGE_W-1:0];
            sh_next  = {sh_reg[RANGE_W-2:0], 1'b0};
            quo_next = {quo_reg[RANGE_W-2:0], ge};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
